@@ hw/rtl/isingchn_pkg.sv @@
// Shared types and constants for the one-dimensional Ising chain spin update block.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package isingchn_pkg;

    // Default sizes of the chain and of the uniform draw.
    localparam int NSPIN_DEFAULT     = 64;
    localparam int DRAW_BITS_DEFAULT = 16;

    // Fixed field widths.
    localparam int SITE_W   = 6;
    localparam int DRAW_W   = 16;
    localparam int THRESH_W = DRAW_W + 1;
    localparam int SUM_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THRESH_W;
    localparam int NUM_THRESH = 6;

    // Sites that the site field can reach.
    localparam int SITE_COUNT = 1 << SITE_W;

    // Threshold reset value: 1.0 at a 16-bit fraction.
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1 << DRAW_W);

    typedef logic [THRESH_W-1:0] thresh_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLING_MODE  = 3'd0,
        CFG_THR_DOWN_NEG   = 3'd1,
        CFG_THR_DOWN_ZERO  = 3'd2,
        CFG_THR_DOWN_POS   = 3'd3,
        CFG_THR_UP_NEG     = 3'd4,
        CFG_THR_UP_ZERO    = 3'd5,
        CFG_THR_UP_POS     = 3'd6
    } cfg_index_t;

    // Sampling mode codes.
    localparam logic MODE_GIBBS      = 1'b0;
    localparam logic MODE_METROPOLIS = 1'b1;

    // Command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Offset of the "old spin up" group in the threshold bank.
    localparam int THR_UP_BASE = 3;

endpackage

`default_nettype wire

@@ hw/rtl/ising_chain_spin_update.sv @@
// Top level of the one-dimensional Ising chain spin update block.
// Depends on isingchn_pkg for field widths, register indexes and mode codes.
`default_nettype none

// The block keeps a ring of NSPIN one-bit spins (1 means +1, 0 means -1) with
// periodic wrap, so site 0 neighbours site NSPIN-1. Each request either loads
// one spin directly or makes one sampling attempt at a site with a uniform
// 16-bit draw. In Metropolis mode the spin flips when the draw is at most the
// threshold chosen by the old spin and the neighbour sum; in Gibbs mode the
// spin becomes +1 when the draw is below the threshold chosen by the
// neighbour sum alone. Every request yields exactly one result carrying the
// new spin, a flip flag and the running spin sum and bond sum (both modulo
// 256), from which software forms the energy as -J*bond_sum - h*spin_sum.
// A request whose site is at or beyond NSPIN changes nothing and returns a
// zero spin with the current sums. The block takes one request per clock
// cycle while out_stall is low: a request is registered on entry, then
// evaluated against the spin register (three bit selects, one threshold
// compare) and written back while its result is captured in the output
// register, so a back-to-back stream runs at one request per cycle. Because
// the spins are written in request order as each one leaves the input
// register, a request always sees the spins left by the one before it.
// Configuration writes are meant to be made while no request is in flight.
module ising_chain_spin_update
    import isingchn_pkg::*;
#(
    parameter int NSPIN     = NSPIN_DEFAULT,
    parameter int DRAW_BITS = DRAW_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // Request channel.
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  command,
    input  wire logic [SITE_W-1:0]     site,
    input  wire logic [DRAW_W-1:0]     uniform_draw,
    input  wire logic                  load_value,

    // Result channel.
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       new_spin,
    output logic                       flipped,
    output logic signed [SUM_W-1:0]    spin_sum,
    output logic signed [SUM_W-1:0]    bond_sum
);

    // Only the first SITE_COUNT spins can ever be written; any spin beyond
    // them keeps its reset value of +1 and needs no storage.
    localparam int NStore  = (NSPIN < SITE_COUNT) ? NSPIN : SITE_COUNT;
    localparam int IdxW    = $clog2(NSPIN);
    localparam int SIdxW   = (NStore > 1) ? $clog2(NStore) : 1;
    localparam int UsedBits = (DRAW_BITS < DRAW_W) ? DRAW_BITS : DRAW_W;
    localparam logic [DRAW_W-1:0] DrawMask = DRAW_W'((64'(1) << UsedBits) - 64'(1));
    localparam logic [SUM_W-1:0] SumReset = SUM_W'(NSPIN);
    localparam logic [SUM_W-1:0] SpinUpDelta   = SUM_W'(-2);
    localparam logic [SUM_W-1:0] SpinDownDelta = SUM_W'(2);
    localparam logic [SUM_W-1:0] BondAlignDelta  = SUM_W'(-4);
    localparam logic [SUM_W-1:0] BondOpposeDelta = SUM_W'(4);

    // Configuration registers.
    logic    mode_reg;
    thresh_t thresh_reg [NUM_THRESH];

    // Chain state.
    logic [NStore-1:0] spins_reg, spins_next;
    logic [SUM_W-1:0]  spin_sum_reg, spin_sum_next;
    logic [SUM_W-1:0]  bond_sum_reg, bond_sum_next;

    // Input register.
    logic              s1_valid_reg;
    logic              s1_command_reg;
    logic [SITE_W-1:0] s1_site_reg;
    logic [DRAW_W-1:0] s1_draw_reg;
    logic              s1_load_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_spin_reg;
    logic              out_flip_reg;
    logic [SUM_W-1:0]  out_spin_sum_reg;
    logic [SUM_W-1:0]  out_bond_sum_reg;

    // Evaluation stage signals.
    logic              advance;
    logic              accept;
    logic              in_range;
    logic [IdxW-1:0]   site_idx;
    logic [IdxW-1:0]   left_idx;
    logic [IdxW-1:0]   right_idx;
    logic              old_spin;
    logic              left_spin;
    logic              right_spin;
    logic [1:0]        up_count;
    logic [2:0]        thr_sel;
    thresh_t           thr_val;
    logic [DRAW_W-1:0] draw_used;
    logic [THRESH_W-1:0] draw_ext;
    logic              spin_new;
    logic              spin_flip;

    // Reads one spin of the ring; sites without storage always hold +1.
    function automatic logic read_spin(input logic [NStore-1:0] vec,
                                       input logic [IdxW-1:0] idx);
        logic bit_val;
        bit_val = 1'b1;
        if (int'(idx) < NStore)
        begin
            bit_val = vec[idx[SIdxW-1:0]];
        end
        return bit_val;
    endfunction

    // The input register moves on when the output register is free or is
    // being emptied in this cycle.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Neighbour addresses with periodic wrap.
    always_comb
    begin
        site_idx  = IdxW'(s1_site_reg);
        in_range  = (int'(s1_site_reg) < NSPIN);
        left_idx  = (site_idx == '0) ? IdxW'(NSPIN - 1) : site_idx - IdxW'(1);
        right_idx = (int'(site_idx) + 1 >= NSPIN) ? '0 : site_idx + IdxW'(1);
    end

    assign old_spin   = read_spin(spins_reg, site_idx);
    assign left_spin  = read_spin(spins_reg, left_idx);
    assign right_spin = read_spin(spins_reg, right_idx);

    // Number of up neighbours: 0, 1, 2 stand for neighbour sum -2, 0, +2.
    assign up_count = {1'b0, left_spin} + {1'b0, right_spin};

    // Threshold selection and the acceptance decision.
    always_comb
    begin
        draw_used = s1_draw_reg & DrawMask;
        draw_ext  = {1'b0, draw_used};
        if (mode_reg == MODE_METROPOLIS && old_spin)
        begin
            thr_sel = 3'(THR_UP_BASE) + {1'b0, up_count};
        end
        else
        begin
            thr_sel = {1'b0, up_count};
        end
        thr_val = thresh_reg[thr_sel];

        spin_new = 1'b0;
        if (in_range)
        begin
            if (s1_command_reg == CMD_LOAD)
            begin
                spin_new = s1_load_reg;
            end
            else if (mode_reg == MODE_METROPOLIS)
            begin
                spin_new = (draw_ext <= thr_val) ? !old_spin : old_spin;
            end
            else
            begin
                spin_new = (draw_ext < thr_val);
            end
        end
        spin_flip = in_range && (spin_new != old_spin);
    end

    // Write-back of the spin and incremental update of both sums. A flip
    // moves the spin sum by two; the bond sum moves by four only when both
    // neighbours agree, down if they agreed with the old spin.
    always_comb
    begin
        spins_next    = spins_reg;
        spin_sum_next = spin_sum_reg;
        bond_sum_next = bond_sum_reg;
        if (advance && spin_flip)
        begin
            spins_next[site_idx[SIdxW-1:0]] = spin_new;
            spin_sum_next = spin_sum_reg + (old_spin ? SpinUpDelta : SpinDownDelta);
            if (left_spin == right_spin)
            begin
                bond_sum_next = bond_sum_reg +
                                ((left_spin == old_spin) ? BondAlignDelta : BondOpposeDelta);
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_METROPOLIS;
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                thresh_reg[i] <= THRESH_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLING_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                CFG_THR_DOWN_NEG, CFG_THR_DOWN_ZERO, CFG_THR_DOWN_POS,
                CFG_THR_UP_NEG, CFG_THR_UP_ZERO, CFG_THR_UP_POS:
                begin
                    thresh_reg[cfg_index - CFG_IDX_W'(CFG_THR_DOWN_NEG)] <= cfg_data;
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    // Chain state and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spins_reg     <= '1;
            spin_sum_reg  <= SumReset;
            bond_sum_reg  <= SumReset;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spins_reg    <= spins_next;
            spin_sum_reg <= spin_sum_next;
            bond_sum_reg <= bond_sum_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_command_reg <= command;
            s1_site_reg    <= site;
            s1_draw_reg    <= uniform_draw;
            s1_load_reg    <= load_value;
        end
        if (advance)
        begin
            out_spin_reg     <= spin_new;
            out_flip_reg     <= spin_flip;
            out_spin_sum_reg <= spin_sum_next;
            out_bond_sum_reg <= bond_sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_spin  = out_spin_reg;
    assign flipped   = out_flip_reg;
    assign spin_sum  = out_spin_sum_reg;
    assign bond_sum  = out_bond_sum_reg;

endmodule

`default_nettype wire

@@ hw/rtl/isingchn_checker.sv @@
// Port checker for the Ising chain spin update block, with its bind statement.
// Depends on isingchn_pkg and watches only the top level's ports.
`default_nettype none

module isingchn_checker
    import isingchn_pkg::*;
#(
    parameter int NSPIN = NSPIN_DEFAULT
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic                 new_spin,
    input wire logic                 flipped,
    input wire logic signed [SUM_W-1:0] spin_sum,
    input wire logic signed [SUM_W-1:0] bond_sum
);

    localparam logic [1:0] RingLow = 2'(NSPIN);

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({new_spin, flipped, spin_sum, bond_sum}))
        else $error("result payload changed while stalled");

    // A sum of NSPIN terms of +1 and -1 has the parity of NSPIN.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> spin_sum[0] == RingLow[0])
        else $error("spin sum has the wrong parity");

    // Around a ring the count of broken bonds is even, so the bond sum
    // matches NSPIN modulo four.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bond_sum[1:0] == RingLow)
        else $error("bond sum inconsistent with a closed ring");

    // A result that appears on an empty output comes from a request that passed
    // through the input register without stalling.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching request");

endmodule

bind ising_chain_spin_update isingchn_checker #(
    .NSPIN(NSPIN)
) u_isingchn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_spin  (new_spin),
    .flipped   (flipped),
    .spin_sum  (spin_sum),
    .bond_sum  (bond_sum)
);

`default_nettype wire
